### rtl/sfcrc_pkg.sv
`default_nettype none
package sfcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  HDR0     = 8'h42;
  localparam logic [7:0]  HDR1     = 8'h4D;

  // Byte positions within the 17-byte reply frame
  localparam logic [4:0] POS_HDR0      = 5'd0;
  localparam logic [4:0] POS_HDR1      = 5'd1;
  localparam logic [4:0] POS_CRC_FIRST = 5'd2;
  localparam logic [4:0] POS_MEAS_LO   = 5'd9;
  localparam logic [4:0] POS_CRC_LAST  = 5'd14;
  localparam logic [4:0] POS_CRC_LO    = 5'd15;
  localparam logic [4:0] POS_CRC_HI    = 5'd16;
  localparam logic [4:0] POS_IDLE      = 5'd17;

  localparam int MEAS_W = 48;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_HDR = 2'd1,
    STATUS_BAD_CRC = 2'd2
  } status_t;

  // One byte of CRC-16/MODBUS, reflected, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/sensor_frame_crc16_checker.sv
// Channel  Direction  Payload
// s_axis   in         tdata[7:0] rx_byte, tuser frame_first
// m_axis   out        tdata[1:0] status, tdata[49:2] measurement, tdata[55:50] zero
//
// One byte per cycle, save when the last frame byte waits on a held result: each byte
// is taken into the input register, where a byte-wide unrolled CRC update feeds the
// frame state, and the result of the last frame byte goes on to the output register.
// Reset is synchronous and leaves the block idle until a first-flagged byte.
// While a result waits on m_axis, bytes that make no result still flow;
// only the last frame byte holds in the input register.
`default_nettype none
module sensor_frame_crc16_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] frame_first
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata    // [1:0] status, [49:2] measurement, [55:50] zero
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_first;

  logic [4:0]  byte_position, byte_position_next;
  logic [15:0] crc_accumulator, crc_accumulator_next;
  logic        header_good, header_good_next;
  logic [sfcrc_pkg::MEAS_W-1:0] measurement_store, measurement_store_next;
  logic [7:0]  crc_low_seen, crc_low_seen_next;

  logic        out_vld;
  logic [1:0]  out_status;
  logic [sfcrc_pkg::MEAS_W-1:0] out_meas;

  logic        produces;
  logic        consume;
  logic        out_free;
  logic [4:0]  pos;
  sfcrc_pkg::status_t res_status;
  logic [sfcrc_pkg::MEAS_W-1:0] res_meas;

  always_comb begin
    pos                    = byte_position;
    crc_accumulator_next   = crc_accumulator;
    header_good_next       = header_good;
    measurement_store_next = measurement_store;
    crc_low_seen_next      = crc_low_seen;
    produces               = 1'b0;
    res_status             = sfcrc_pkg::STATUS_GOOD;
    res_meas               = '0;
    // restart the frame on the first flag, dropping any frame in progress
    if (in_first) begin
      pos                    = sfcrc_pkg::POS_HDR0;
      crc_accumulator_next   = sfcrc_pkg::CRC_INIT;
      header_good_next       = 1'b0;
      measurement_store_next = '0;
      crc_low_seen_next      = '0;
    end
    byte_position_next = pos + 5'd1;
    case (pos) inside
      sfcrc_pkg::POS_HDR0: begin
        header_good_next = (in_byte == sfcrc_pkg::HDR0);
      end
      sfcrc_pkg::POS_HDR1: begin
        header_good_next = header_good_next && (in_byte == sfcrc_pkg::HDR1);
      end
      [sfcrc_pkg::POS_CRC_FIRST:sfcrc_pkg::POS_CRC_LAST]: begin
        crc_accumulator_next = sfcrc_pkg::crc_byte(crc_accumulator_next, in_byte);
        if (pos >= sfcrc_pkg::POS_MEAS_LO)
          measurement_store_next = {measurement_store_next[sfcrc_pkg::MEAS_W-9:0], in_byte};
      end
      sfcrc_pkg::POS_CRC_LO: begin
        crc_low_seen_next = in_byte;
      end
      sfcrc_pkg::POS_CRC_HI: begin
        produces           = 1'b1;
        byte_position_next = sfcrc_pkg::POS_IDLE;
        if (!header_good_next)
          res_status = sfcrc_pkg::STATUS_BAD_HDR;
        else if (crc_low_seen_next == crc_accumulator_next[7:0] &&
                 in_byte == crc_accumulator_next[15:8])
          res_status = sfcrc_pkg::STATUS_GOOD;
        else
          res_status = sfcrc_pkg::STATUS_BAD_CRC;
        if (res_status == sfcrc_pkg::STATUS_GOOD)
          res_meas = measurement_store_next;
      end
      default: begin
        // idle: ignore the byte
        byte_position_next = sfcrc_pkg::POS_IDLE;
      end
    endcase
  end

  assign out_free      = !out_vld || m_axis_tready;
  assign consume       = in_vld && (!produces || out_free);
  assign s_axis_tready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld            <= 1'b0;
      out_vld           <= 1'b0;
      byte_position     <= sfcrc_pkg::POS_IDLE;
      crc_accumulator   <= sfcrc_pkg::CRC_INIT;
      header_good       <= 1'b0;
      measurement_store <= '0;
      crc_low_seen      <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld   <= 1'b1;
        in_byte  <= s_axis_tdata;
        in_first <= s_axis_tuser;
      end else if (consume) begin
        in_vld <= 1'b0;
      end
      if (consume) begin
        byte_position     <= byte_position_next;
        crc_accumulator   <= crc_accumulator_next;
        header_good       <= header_good_next;
        measurement_store <= measurement_store_next;
        crc_low_seen      <= crc_low_seen_next;
      end
      if (consume && produces) begin
        out_vld    <= 1'b1;
        out_status <= res_status;
        out_meas   <= res_meas;
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {6'd0, out_meas, out_status};

endmodule
`default_nettype wire

### rtl/sfcrc_checker.sv
`default_nettype none
module sfcrc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_meas_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[49:2] == 48'd0)
    else $error("measurement not cleared on a bad frame");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
    else $error("padding bits set");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind sensor_frame_crc16_checker sfcrc_checker u_sfcrc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
